FILE: sv/sbc_pkg.sv
package sbc_pkg;

  localparam int COMP_W = 20;
  localparam int VEC_W = 3 * COMP_W;
  localparam int RAD_W = COMP_W - 1;
  localparam int ROT_FRAC = COMP_W - 2;
  localparam int EXTRA = 6;

  localparam int DIFF_W = COMP_W + 1;
  localparam int PROD_W = COMP_W + DIFF_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int LOC_W = ACC_W - (ROT_FRAC - 1);
  localparam int Q_W = COMP_W + 1;
  localparam int SQ_W = 2 * LOC_W - 1;
  localparam int D2_W = SQ_W + 2;
  localparam int PT_SHIFT = ROT_FRAC + 1;
  localparam int PT_RND_W = ACC_W - PT_SHIFT;
  localparam int MAG_W = ACC_W - 1;

  // A hit needs the distance below the radius, which bounds the squared distance.
  localparam int NEAR_W = 2 * (RAD_W + 1);
  localparam int SQ_ARG_W = NEAR_W + 2 * EXTRA;
  localparam int SQ_ROOT_W = SQ_ARG_W / 2;

  localparam int NUM_W = MAG_W + EXTRA + 1;
  localparam int DEN_W = SQ_ROOT_W;
  localparam int QUO_W = COMP_W - 1;
  localparam int DIV_STAGES = QUO_W + 1;

  localparam int FRONT_STAGES = 7;
  localparam int PIPE_REGS = FRONT_STAGES + SQ_ROOT_W + 1 + DIV_STAGES + 1;

endpackage

FILE: sv/sphere_box_contact.sv
// Sphere against oriented box contact test, one pair per item.
// An item is offered on the in_ ports with start; it is taken at any rising
// edge where start is high and busy is low. busy is always low: the pipeline
// takes a new item in every cycle, one pair per clock sustained.
// The item moves through seven arithmetic stages, a 26-stage square root that
// resolves one root bit per stage, one stage of setup and a 20-stage divider
// (three lanes, one per normal component) that checks for overflow in its first
// stage and then resolves one quotient bit per stage. The registered strobe
// out_valid stays high for exactly one cycle per item, in the order of acceptance.
// A missed pair still produces an item with every field zero.
// The receiver cannot hold results off, so nothing ever waits in the block.
// Reset clears every valid bit; items in flight at reset are dropped and no
// result appears until a new item has passed the full pipeline.
module sphere_box_contact (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sbc_pkg::VEC_W-1:0]     in_sphere_center,
  input  logic [sbc_pkg::RAD_W-1:0]     in_sphere_radius,
  input  logic [sbc_pkg::VEC_W-1:0]     in_box_center,
  input  logic [sbc_pkg::VEC_W-1:0]     in_box_size,
  input  logic [sbc_pkg::VEC_W-1:0]     in_rot_row_a,
  input  logic [sbc_pkg::VEC_W-1:0]     in_rot_row_b,
  input  logic [sbc_pkg::VEC_W-1:0]     in_rot_row_c,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic                          out_degenerate,
  output logic [sbc_pkg::VEC_W-1:0]     out_contact_point,
  output logic [sbc_pkg::VEC_W-1:0]     out_contact_normal,
  output logic [sbc_pkg::RAD_W-1:0]     out_depth
);

  localparam int CW = sbc_pkg::COMP_W;
  localparam int VW = sbc_pkg::VEC_W;
  localparam int RDW = sbc_pkg::RAD_W;
  localparam int RF = sbc_pkg::ROT_FRAC;
  localparam int EX = sbc_pkg::EXTRA;
  localparam int DFW = sbc_pkg::DIFF_W;
  localparam int PW = sbc_pkg::PROD_W;
  localparam int ACW = sbc_pkg::ACC_W;
  localparam int LW = sbc_pkg::LOC_W;
  localparam int QW = sbc_pkg::Q_W;
  localparam int SQW = sbc_pkg::SQ_W;
  localparam int D2W = sbc_pkg::D2_W;
  localparam int PS = sbc_pkg::PT_SHIFT;
  localparam int PRW = sbc_pkg::PT_RND_W;
  localparam int MW = sbc_pkg::MAG_W;
  localparam int NRW = sbc_pkg::NEAR_W;
  localparam int SAW = sbc_pkg::SQ_ARG_W;
  localparam int SRW = sbc_pkg::SQ_ROOT_W;
  localparam int NMW = sbc_pkg::NUM_W;
  localparam int QUW = sbc_pkg::QUO_W;
  localparam int DS = sbc_pkg::DIV_STAGES;

  typedef logic signed [CW-1:0] comp_t;

  localparam comp_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic                   big;
    logic                   zero;
    logic [RDW-1:0]         rad;
    logic [VW-1:0]          pt;
    logic [2:0][MW-1:0]     mag;
    logic [2:0]             neg;
  } side_t;

  typedef struct packed {
    logic                   hit;
    logic                   degen;
    logic [VW-1:0]          pt;
    logic [RDW-1:0]         depth;
    logic [2:0]             neg;
  } res_t;

  function automatic comp_t sat_comp(input logic signed [PRW:0] v);
    comp_t r;
    r = comp_t'(v);
    if (v > (PRW+1)'(CMAX)) begin
      r = CMAX;
    end else if (v < (PRW+1)'(CMIN)) begin
      r = CMIN;
    end
    return r;
  endfunction

  logic accept;

  comp_t                   sc_w [3];
  comp_t                   bc_w [3];
  comp_t                   rot_w [3][3];
  logic [CW-1:0]           h_w [3];

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  logic signed [DFW-1:0]   d1_r [3];
  comp_t                   rot1_r [3][3];
  comp_t                   bc1_r [3];
  logic [CW-1:0]           h1_r [3];
  logic [RDW-1:0]          rad1_r;

  logic signed [PW-1:0]    prod2_r [3][3];
  comp_t                   rot2_r [3][3];
  comp_t                   bc2_r [3];
  logic [CW-1:0]           h2_r [3];
  logic [RDW-1:0]          rad2_r;

  logic signed [ACW-1:0]   acc3_w [3];
  logic signed [LW-1:0]    loc3_r [3];
  comp_t                   rot3_r [3][3];
  comp_t                   bc3_r [3];
  logic [CW-1:0]           h3_r [3];
  logic [RDW-1:0]          rad3_r;

  logic signed [LW-1:0]    hs4_w [3];
  logic signed [LW-1:0]    qf4_w [3];
  logic signed [QW-1:0]    q4_r [3];
  logic signed [LW-1:0]    dx4_r [3];
  comp_t                   rot4_r [3][3];
  comp_t                   bc4_r [3];
  logic [RDW-1:0]          rad4_r;

  logic signed [2*LW-1:0]  sqp5_w [3];
  logic [SQW-1:0]          sq5_r [3];
  logic signed [PW-1:0]    pp5_r [3][3];
  logic signed [PW-1:0]    pn5_r [3][3];
  comp_t                   bc5_r [3];
  logic [RDW-1:0]          rad5_r;

  logic [D2W-1:0]          d2_6_r;
  logic signed [ACW-1:0]   accp6_r [3];
  logic signed [ACW-1:0]   accn6_r [3];
  comp_t                   bc6_r [3];
  logic [RDW-1:0]          rad6_r;

  side_t                   side7_nxt;
  side_t                   side7_r;
  logic [SAW-1:0]          arg7_r;
  side_t                   sd_r [SRW];

  logic                    sq_valid;
  logic [SRW-1:0]          dist_hi;

  res_t                    res8_nxt;
  res_t                    res8_r;
  logic [NMW-1:0]          num8_nxt [3];
  logic [NMW-1:0]          num8_r [3];
  logic [SRW-1:0]          den8_r;
  res_t                    rd_r [DS];

  logic [2:0]              dv_valid;
  logic [2:0]              dv_ovf;
  logic [QUW-1:0]          dv_quo [3];

  res_t                    fin_w;
  logic [VW-1:0]           nrm_w;

  assign busy = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc_w[i] = $signed(in_sphere_center[i*CW +: CW]);
      bc_w[i] = $signed(in_box_center[i*CW +: CW]);
      h_w[i] = in_box_size[i*CW +: CW];
      rot_w[0][i] = $signed(in_rot_row_a[i*CW +: CW]);
      rot_w[1][i] = $signed(in_rot_row_b[i*CW +: CW]);
      rot_w[2][i] = $signed(in_rot_row_c[i*CW +: CW]);
    end
  end

  // Local coordinate: transpose of the rotation times the offset, rounded.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc3_w[i] = ACW'(prod2_r[i][0]) + ACW'(prod2_r[i][1]) + ACW'(prod2_r[i][2])
                + (ACW'(1) << (RF - 2));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hs4_w[i] = LW'($signed({1'b0, h3_r[i]}));
      qf4_w[i] = (loc3_r[i] > hs4_w[i]) ? hs4_w[i] :
                 ((loc3_r[i] < -hs4_w[i]) ? -hs4_w[i] : loc3_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp5_w[i] = (2*LW)'(dx4_r[i]) * (2*LW)'(dx4_r[i]);
    end
  end

  always_comb begin
    logic signed [ACW-1:0] rnd;
    logic signed [PRW-1:0] rsh;
    logic signed [PRW:0]   psum;
    logic signed [ACW-1:0] negv;
    side7_nxt = '0;
    side7_nxt.big = |d2_6_r[D2W-1:NRW];
    side7_nxt.zero = (d2_6_r == '0);
    side7_nxt.rad = rad6_r;
    for (int i = 0; i < 3; i++) begin
      rnd = accp6_r[i] + (ACW'(1) << (PS - 1));
      rsh = $signed(rnd[ACW-1:PS]);
      psum = (PRW+1)'(rsh) + (PRW+1)'(bc6_r[i]);
      side7_nxt.pt[i*CW +: CW] = sat_comp(psum);
      negv = -accn6_r[i];
      side7_nxt.neg[i] = accn6_r[i][ACW-1];
      side7_nxt.mag[i] = accn6_r[i][ACW-1] ? negv[MW-1:0] : accn6_r[i][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1_r[i] <= DFW'(sc_w[i]) - DFW'(bc_w[i]);
      bc1_r[i] <= bc_w[i];
      h1_r[i] <= h_w[i];
      for (int j = 0; j < 3; j++) begin
        rot1_r[i][j] <= rot_w[i][j];
        prod2_r[i][j] <= PW'(rot1_r[j][i]) * PW'(d1_r[j]);
        pp5_r[i][j] <= PW'(rot4_r[i][j]) * PW'(q4_r[j]);
        pn5_r[i][j] <= PW'(rot4_r[i][j]) * PW'($signed(dx4_r[j][QW-1:0]));
      end
      loc3_r[i] <= $signed(acc3_w[i][ACW-1:RF-1]);
      q4_r[i] <= qf4_w[i][QW-1:0];
      dx4_r[i] <= loc3_r[i] - qf4_w[i];
      sq5_r[i] <= sqp5_w[i][SQW-1:0];
      accp6_r[i] <= ACW'(pp5_r[i][0]) + ACW'(pp5_r[i][1]) + ACW'(pp5_r[i][2]);
      accn6_r[i] <= ACW'(pn5_r[i][0]) + ACW'(pn5_r[i][1]) + ACW'(pn5_r[i][2]);
    end
    rad1_r <= in_sphere_radius;
    rot2_r <= rot1_r;
    bc2_r <= bc1_r;
    h2_r <= h1_r;
    rad2_r <= rad1_r;
    rot3_r <= rot2_r;
    bc3_r <= bc2_r;
    h3_r <= h2_r;
    rad3_r <= rad2_r;
    rot4_r <= rot3_r;
    bc4_r <= bc3_r;
    rad4_r <= rad3_r;
    bc5_r <= bc4_r;
    rad5_r <= rad4_r;
    d2_6_r <= D2W'(sq5_r[0]) + D2W'(sq5_r[1]) + D2W'(sq5_r[2]);
    bc6_r <= bc5_r;
    rad6_r <= rad5_r;
    side7_r <= side7_nxt;
    arg7_r <= {d2_6_r[NRW-1:0], {(2*EX){1'b0}}};
    sd_r[0] <= side7_r;
    for (int s = 1; s < SRW; s++) begin
      sd_r[s] <= sd_r[s-1];
    end
    res8_r <= res8_nxt;
    for (int i = 0; i < 3; i++) begin
      num8_r[i] <= num8_nxt[i];
    end
    den8_r <= dist_hi;
    rd_r[0] <= res8_r;
    for (int s = 1; s < DS; s++) begin
      rd_r[s] <= rd_r[s-1];
    end
    out_hit <= fin_w.hit;
    out_degenerate <= fin_w.degen;
    out_contact_point <= fin_w.hit ? fin_w.pt : '0;
    out_contact_normal <= (fin_w.hit && !fin_w.degen) ? nrm_w : '0;
    out_depth <= fin_w.depth;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= sq_valid;
      out_valid <= &dv_valid;
    end
  end

  sbc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v7_r),
    .arg       (arg7_r),
    .out_valid (sq_valid),
    .root      (dist_hi)
  );

  always_comb begin
    logic [SRW-1:0] r_hi;
    logic [SRW:0]   dep;
    side_t          sd;
    sd = sd_r[SRW-1];
    r_hi = {sd.rad, {(EX+1){1'b0}}};
    dep = (SRW+1)'(r_hi - dist_hi) + ((SRW+1)'(1) << EX);
    res8_nxt.hit = !sd.big && (dist_hi < r_hi);
    res8_nxt.degen = res8_nxt.hit && sd.zero;
    res8_nxt.pt = sd.pt;
    res8_nxt.depth = res8_nxt.hit ? dep[SRW-1:EX+1] : '0;
    res8_nxt.neg = sd.neg;
    for (int i = 0; i < 3; i++) begin
      num8_nxt[i] = NMW'({sd.mag[i], {EX{1'b0}}}) + NMW'(dist_hi >> 1);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sbc_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v8_r),
      .num       (num8_r[i]),
      .den       (den8_r),
      .out_valid (dv_valid[i]),
      .ovf       (dv_ovf[i]),
      .quo       (dv_quo[i])
    );
  end

  always_comb begin
    comp_t qs;
    fin_w = rd_r[DS-1];
    nrm_w = '0;
    for (int i = 0; i < 3; i++) begin
      qs = $signed({1'b0, dv_quo[i]});
      if (dv_ovf[i]) begin
        nrm_w[i*CW +: CW] = fin_w.neg[i] ? CMIN : CMAX;
      end else begin
        nrm_w[i*CW +: CW] = fin_w.neg[i] ? -qs : qs;
      end
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, sbc_pkg::PIPE_REGS))
    else $error("result strobe without a matching accepted item");

  a_degen_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_hit)
    else $error("degenerate flag without a hit");

  a_degen_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_contact_normal == '0)
    else $error("degenerate item carries a nonzero normal");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_depth == '0 && out_contact_point == '0
                              && out_contact_normal == '0)
    else $error("missed pair carries nonzero fields");
`endif

endmodule

FILE: sv/sbc_sqrt.sv
module sbc_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [sbc_pkg::SQ_ARG_W-1:0]   arg,
  output logic                           out_valid,
  output logic [sbc_pkg::SQ_ROOT_W-1:0]  root
);

  localparam int N = sbc_pkg::SQ_ROOT_W;
  localparam int RW = sbc_pkg::SQ_ARG_W + 2;

  logic [RW-1:0] rem_r [N];
  logic [RW-1:0] rem_nxt [N];
  logic [N-1:0]  root_r [N];
  logic [N-1:0]  root_nxt [N];
  logic [N-1:0]  vld_r;

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam int K = N - 1 - s;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] trial;
    logic [N-1:0]  root_in;
    logic          take;
    if (s == 0) begin : g_first
      assign rem_in = RW'(arg);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign root_in = root_r[s-1];
    end
    assign trial = (RW'(root_in) << (K + 1)) | (RW'(1) << (2 * K));
    assign take = rem_in >= trial;
    assign rem_nxt[s] = take ? rem_in - trial : rem_in;
    assign root_nxt[s] = take ? (root_in | (N'(1) << K)) : root_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      rem_r[s] <= rem_nxt[s];
      root_r[s] <= root_nxt[s];
    end
  end

  assign out_valid = vld_r[N-1];
  assign root = root_r[N-1];

endmodule

FILE: sv/sbc_div.sv
module sbc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [sbc_pkg::NUM_W-1:0]  num,
  input  logic [sbc_pkg::DEN_W-1:0]  den,
  output logic                       out_valid,
  output logic                       ovf,
  output logic [sbc_pkg::QUO_W-1:0]  quo
);

  localparam int NW = sbc_pkg::NUM_W;
  localparam int DW = sbc_pkg::DEN_W;
  localparam int QW = sbc_pkg::QUO_W;
  localparam int NS = sbc_pkg::DIV_STAGES;

  logic [NW-1:0] rem_r [NS];
  logic [NW-1:0] rem_nxt [NS];
  logic [QW-1:0] quo_r [NS];
  logic [QW-1:0] quo_nxt [NS];
  logic [DW-1:0] den_r [NS];
  logic [DW-1:0] den_nxt [NS];
  logic          ovf_r [NS];
  logic          ovf_nxt [NS];
  logic [NS-1:0] vld_r;

  for (genvar s = 0; s < NS; s++) begin : g_step
    if (s == 0) begin : g_check
      assign rem_nxt[s] = num;
      assign quo_nxt[s] = '0;
      assign den_nxt[s] = den;
      assign ovf_nxt[s] = num >= (NW'(den) << QW);
    end else begin : g_bit
      localparam int K = QW - s;
      logic [NW-1:0] sub;
      logic          take;
      assign sub = NW'(den_r[s-1]) << K;
      assign take = rem_r[s-1] >= sub;
      assign rem_nxt[s] = take ? rem_r[s-1] - sub : rem_r[s-1];
      assign quo_nxt[s] = take ? (quo_r[s-1] | (QW'(1) << K)) : quo_r[s-1];
      assign den_nxt[s] = den_r[s-1];
      assign ovf_nxt[s] = ovf_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
      den_r[s] <= den_nxt[s];
      ovf_r[s] <= ovf_nxt[s];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign ovf = ovf_r[NS-1];
  assign quo = quo_r[NS-1];

endmodule

FILE: bench/tb_sphere_box_contact.sv
`timescale 1ns / 1ps

module tb_sphere_box_contact;

  localparam int COMP_W = sbc_pkg::COMP_W;
  localparam int VEC_W = sbc_pkg::VEC_W;
  localparam int RAD_W = sbc_pkg::RAD_W;
  localparam int ROT_FRAC = sbc_pkg::ROT_FRAC;
  localparam int EXTRA = sbc_pkg::EXTRA;

  localparam longint ONE_ROT = 64'sd1 << ROT_FRAC;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    bit             hit;
    bit             degen;
    bit [VEC_W-1:0] point;
    bit [VEC_W-1:0] normal;
    bit [RAD_W-1:0] depth;
  } contact_t;

  typedef struct {
    bit [VEC_W-1:0] sphere;
    bit [RAD_W-1:0] radius;
    bit [VEC_W-1:0] box;
    bit [VEC_W-1:0] size;
    bit [VEC_W-1:0] row_a;
    bit [VEC_W-1:0] row_b;
    bit [VEC_W-1:0] row_c;
  } pair_t;

  class contact_scoreboard;
    contact_t pending[$];
    int errors;
    int checked;
    int hits;
    int degens;

    function longint comp_s(bit [VEC_W-1:0] v, int k);
      logic signed [COMP_W-1:0] c;
      c = v[k*COMP_W +: COMP_W];
      return longint'(c);
    endfunction

    function longint clamp_comp(longint v);
      longint hi;
      hi = (64'sd1 << (COMP_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function contact_t predict_contact(pair_t p);
      longint rot[3][3];
      longint d[3], bc[3], q[3], dx[3], pt[3], nrm[3];
      longint acc, loc, h, accp, accn, qv;
      longint unsigned dist2, dist_hi, r_hi, mag, depth_hi;
      contact_t r;
      r = '{default: 0};
      dist2 = 0;
      for (int i = 0; i < 3; i++) begin
        rot[0][i] = comp_s(p.row_a, i);
        rot[1][i] = comp_s(p.row_b, i);
        rot[2][i] = comp_s(p.row_c, i);
        bc[i] = comp_s(p.box, i);
        d[i] = comp_s(p.sphere, i) - bc[i];
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        h = longint'(p.size[i*COMP_W +: COMP_W]);
        for (int j = 0; j < 3; j++) acc += rot[j][i] * d[j];
        loc = (acc + (64'sd1 << (ROT_FRAC - 2))) >>> (ROT_FRAC - 1);
        q[i] = loc > h ? h : (loc < -h ? -h : loc);
        dx[i] = loc - q[i];
        dist2 += longint'(dx[i] * dx[i]);
      end
      r_hi = longint'(p.radius) << (1 + EXTRA);
      if (dist2 >= (64'd1 << 50)) return r;
      dist_hi = int_sqrt(dist2 << (2 * EXTRA));
      if (!(dist_hi < r_hi)) return r;
      r.hit = 1;
      r.degen = (dist2 == 0);
      for (int i = 0; i < 3; i++) begin
        accp = 0;
        accn = 0;
        for (int j = 0; j < 3; j++) begin
          accp += rot[i][j] * q[j];
          accn += rot[i][j] * dx[j];
        end
        pt[i] = clamp_comp(((accp + (64'sd1 << ROT_FRAC)) >>> (ROT_FRAC + 1)) + bc[i]);
        if (r.degen) begin
          nrm[i] = 0;
        end else begin
          mag = longint'(accn < 0 ? -accn : accn) << EXTRA;
          qv = longint'((mag + dist_hi / 2) / dist_hi);
          nrm[i] = clamp_comp(accn < 0 ? -qv : qv);
        end
        r.point[i*COMP_W +: COMP_W] = pt[i][COMP_W-1:0];
        r.normal[i*COMP_W +: COMP_W] = nrm[i][COMP_W-1:0];
      end
      depth_hi = r_hi - dist_hi;
      r.depth = RAD_W'((depth_hi + (64'd1 << EXTRA)) >> (EXTRA + 1));
      return r;
    endfunction

    function void note_pair(pair_t p);
      pending = {pending, predict_contact(p)};
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_contact(contact_t got);
      contact_t want;
      if (pending.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.hit) hits++;
      if (want.degen) degens++;
      if (got.hit !== want.hit)
        report($sformatf("hit got %0b want %0b", got.hit, want.hit));
      if (got.degen !== want.degen)
        report($sformatf("degenerate got %0b want %0b", got.degen, want.degen));
      if (got.point !== want.point)
        report($sformatf("contact_point got %h want %h", got.point, want.point));
      if (got.normal !== want.normal)
        report($sformatf("contact_normal got %h want %h", got.normal, want.normal));
      if (got.depth !== want.depth)
        report($sformatf("depth got %h want %h", got.depth, want.depth));
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VEC_W-1:0] in_sphere_center = '0;
  logic [RAD_W-1:0] in_sphere_radius = '0;
  logic [VEC_W-1:0] in_box_center = '0;
  logic [VEC_W-1:0] in_box_size = '0;
  logic [VEC_W-1:0] in_rot_row_a = '0;
  logic [VEC_W-1:0] in_rot_row_b = '0;
  logic [VEC_W-1:0] in_rot_row_c = '0;
  logic out_valid;
  logic out_hit;
  logic out_degenerate;
  logic [VEC_W-1:0] out_contact_point;
  logic [VEC_W-1:0] out_contact_normal;
  logic [RAD_W-1:0] out_depth;

  contact_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;

  sphere_box_contact u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sphere_center(in_sphere_center), .in_sphere_radius(in_sphere_radius),
    .in_box_center(in_box_center), .in_box_size(in_box_size),
    .in_rot_row_a(in_rot_row_a), .in_rot_row_b(in_rot_row_b),
    .in_rot_row_c(in_rot_row_c), .out_valid(out_valid), .out_hit(out_hit),
    .out_degenerate(out_degenerate), .out_contact_point(out_contact_point),
    .out_contact_normal(out_contact_normal), .out_depth(out_depth)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_pair(pair_t'{in_sphere_center, in_sphere_radius, in_box_center,
                             in_box_size, in_rot_row_a, in_rot_row_b, in_rot_row_c});
      end
      if (out_valid) begin
        sb.check_contact(contact_t'{out_hit, out_degenerate, out_contact_point,
                                    out_contact_normal, out_depth});
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d items outstanding", sb.pending.size());
        $display("tb_sphere_box_contact: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic bit [VEC_W-1:0] pack3(longint x, longint y, longint z);
    bit [VEC_W-1:0] v;
    v[0 +: COMP_W] = x[COMP_W-1:0];
    v[COMP_W +: COMP_W] = y[COMP_W-1:0];
    v[2*COMP_W +: COMP_W] = z[COMP_W-1:0];
    return v;
  endfunction

  function automatic bit [VEC_W-1:0] rand_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  function automatic longint srand(int span);
    return longint'($urandom_range(2 * span, 0)) - span;
  endfunction

  task automatic send_pair(pair_t p);
    bit go;
    start <= 1'b1;
    in_sphere_center <= p.sphere;
    in_sphere_radius <= p.radius;
    in_box_center <= p.box;
    in_box_size <= p.size;
    in_rot_row_a <= p.row_a;
    in_rot_row_b <= p.row_b;
    in_rot_row_c <= p.row_c;
    sent++;
    do begin
      @(negedge clk);
      go = !busy;
      @(posedge clk);
    end while (!go);
  endtask

  task automatic idle_gap();
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) n = 0;
    else if (pick < 93) n = $urandom_range(3, 1);
    else n = $urandom_range(70, 15);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // A signed permutation matrix, sometimes slightly perturbed so the rows are not orthonormal.
  task automatic make_rotation(output pair_t p, input bit wobble);
    int perm[3];
    longint m[3][3];
    int a;
    int t;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      a = $urandom_range(i);
      t = perm[i];
      perm[i] = perm[a];
      perm[a] = t;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        m[i][j] = (perm[i] == j) ? (($urandom_range(1) ? ONE_ROT : -ONE_ROT)) : 0;
        if (wobble) m[i][j] += srand(4000);
        if (m[i][j] >= (64'sd1 << (COMP_W - 1))) m[i][j] = (64'sd1 << (COMP_W - 1)) - 1;
      end
    p.row_a = pack3(m[0][0], m[0][1], m[0][2]);
    p.row_b = pack3(m[1][0], m[1][1], m[1][2]);
    p.row_c = pack3(m[2][0], m[2][1], m[2][2]);
  endtask

  task automatic make_near_pair(output pair_t p);
    longint bx, by, bz, sx, sy, sz, r;
    int span;
    make_rotation(p, $urandom_range(3) == 0);
    span = ($urandom_range(9) == 0) ? 200000 : 60000;
    bx = srand(span);
    by = srand(span);
    bz = srand(span);
    p.box = pack3(bx, by, bz);
    p.size = pack3(longint'($urandom_range(40000)), longint'($urandom_range(40000)),
                   longint'($urandom_range(40000)));
    r = ($urandom_range(9) == 0) ? longint'($urandom_range((1 << RAD_W) - 1))
                                  : longint'($urandom_range(30000));
    p.radius = r[RAD_W-1:0];
    sx = bx + srand(50000);
    sy = by + srand(50000);
    sz = bz + srand(50000);
    p.sphere = pack3(sx, sy, sz);
  endtask

  initial begin
    pair_t p;
    pair_t id;
    int choice;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    id = '{default: 0};
    id.row_a = pack3(ONE_ROT, 0, 0);
    id.row_b = pack3(0, ONE_ROT, 0);
    id.row_c = pack3(0, 0, ONE_ROT);

    send_pair('{default: 0});
    p = id; p.radius = 100;
    send_pair(p);
    p = id; p.radius = 0; p.sphere = pack3(50000, 0, 0);
    send_pair(p);
    p = id; p.size = pack3(4096, 4096, 4096); p.radius = 4096;
    p.sphere = pack3(2048, 1024, 0);
    send_pair(p);
    p.sphere = pack3(6000, 0, 0);
    send_pair(p);
    p.sphere = pack3(6000, 5000, -5000);
    send_pair(p);
    p.sphere = pack3(20000, 0, 0);
    send_pair(p);
    p = id; p.size = pack3(4096, 4096, 4096); p.radius = 2048;
    p.sphere = pack3(8192 + 2048, 0, 0);
    send_pair(p);
    p = id; p.size = {3{20'h80000}}; p.radius = '1; p.sphere = pack3(-524288, 0, 0);
    send_pair(p);
    p = id; p.radius = '1; p.box = pack3(524287, 524287, 524287);
    p.sphere = pack3(-524288, -524288, -524288);
    send_pair(p);
    p = id; p.radius = '1; p.box = pack3(-524288, 0, 0); p.size = pack3(0, 0, 0);
    p.sphere = pack3(-524288 + 20000, 0, 0);
    send_pair(p);
    p = '{sphere: '1, radius: '1, box: '1, size: '1, row_a: '1, row_b: '1, row_c: '1};
    send_pair(p);
    p = '{sphere: {3{20'h80000}}, radius: '1, box: {3{20'h7ffff}}, size: '0,
          row_a: {3{20'h80000}}, row_b: {3{20'h7ffff}}, row_c: {3{20'h80000}}};
    send_pair(p);
    p = id; p.row_a = pack3(-ONE_ROT, 0, 0); p.row_b = pack3(0, 0, ONE_ROT);
    p.row_c = pack3(0, -ONE_ROT, 0); p.size = pack3(3000, 9000, 500);
    p.radius = 9000; p.sphere = pack3(2000, 3000, 6000);
    send_pair(p);

    for (int n = 0; n < 1640; n++) begin
      if (n == 820) begin
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      choice = $urandom_range(99);
      if (choice < 65) begin
        make_near_pair(p);
      end else if (choice < 75) begin
        make_near_pair(p);
        p.sphere = p.box;
        if ($urandom_range(1)) p.radius = 0;
      end else if (choice < 85) begin
        make_near_pair(p);
        p.row_a = rand_vec();
        p.row_b = rand_vec();
        p.row_c = rand_vec();
      end else begin
        p = '{rand_vec(), RAD_W'($urandom), rand_vec(), rand_vec(),
              rand_vec(), rand_vec(), rand_vec()};
      end
      send_pair(p);
      if (n < 1400 || n > 1500) idle_gap();
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d sphere/box pairs, checked %0d results: %0d contacts, %0d degenerate.",
             sent, sb.checked, sb.hits, sb.degens);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_sphere_box_contact: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("tb_sphere_box_contact: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/sbc_pkg.sv
sv/sbc_sqrt.sv
sv/sbc_div.sv
sv/sphere_box_contact.sv
bench/tb_sphere_box_contact.sv
